### hw/rtl/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bem_pkg.sv
// ---------------------------------------------------------------------------
// bem_pkg
// Shared types and constants for the battery energy metrics block.
// ---------------------------------------------------------------------------
package bem_pkg;

  localparam int unsigned StepW = 24;
  localparam int unsigned PctW  = 16;
  localparam int unsigned EnW   = 64;
  localparam logic [15:0] PctScale   = 16'd25600;
  localparam logic [23:0] StepReset  = 24'd65536;
  localparam logic [15:0] PctReset   = 16'd25600;

  typedef enum logic [0:0] {
    CMD_SAMPLE   = 1'b0,
    CMD_NEW_YEAR = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [0:0]  command;
    logic [31:0] grid_power;
    logic [31:0] battery_power;
    logic [30:0] pv_to_battery;
    logic [30:0] grid_to_battery;
    logic [30:0] system_loss_power;
  } in_item_t;

  typedef struct packed {
    logic [15:0] conversion_efficiency;
    logic [15:0] roundtrip_efficiency;
    logic [15:0] pv_share_percent;
    logic [63:0] pv_charge_year;
    logic [63:0] grid_charge_year;
    logic [63:0] charge_year;
    logic [63:0] discharge_year;
    logic [63:0] import_year;
    logic [63:0] export_year;
    logic [63:0] total_loss_year;
    logic [63:0] system_loss_year;
  } out_item_t;

  // Division operand selector.
  typedef enum logic [1:0] {
    DIV_CONV  = 2'd0,
    DIV_ROUND = 2'd1,
    DIV_PV    = 2'd2
  } div_sel_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic     load;      // capture input item
    logic     year_clr;  // clear annual totals except total loss
    logic     energy;    // update pre-division accumulators
    logic     div_start; // load divider operands
    div_sel_e div_sel;
    logic     div_step;  // one restoring step
    logic     div_store; // write quotient to its percent register
    logic     finish;    // charge/discharge/loss update
    logic     out_load;  // capture result
  } cmd_t;

  typedef struct packed {
    logic div_last; // final divider step this cycle
  } sts_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

### hw/rtl/bem_if.sv
// ---------------------------------------------------------------------------
// bem_if
// Valid/ready channel carrying one payload of a chosen type.
// ---------------------------------------------------------------------------
interface bem_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/bem_ctrl.sv
// ---------------------------------------------------------------------------
// bem_ctrl
// Sequencer: accept; energy, three serial divisions, or year clear; result.
// ---------------------------------------------------------------------------
module bem_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_cmd_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  bem_pkg::sts_t  sts_i,
  output bem_pkg::cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ENERGY = 7'b0000010,
    S_DSTART = 7'b0000100,
    S_DRUN   = 7'b0001000,
    S_FINISH = 7'b0010000,
    S_YEAR   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  bem_pkg::div_sel_e  sel_q, sel_d;
  logic               out_valid_q, out_valid_d;

  logic out_free;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.div_sel = sel_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = (in_cmd_i == bem_pkg::CMD_NEW_YEAR) ? S_YEAR : S_ENERGY;
        end
      end
      S_YEAR: begin
        cmd_o.year_clr = 1'b1;
        state_d = S_OUT;
      end
      S_ENERGY: begin
        cmd_o.energy = 1'b1;
        sel_d = bem_pkg::DIV_CONV;
        state_d = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DRUN;
      end
      S_DRUN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.div_store = 1'b1;
          case (sel_q)
            bem_pkg::DIV_CONV:  begin sel_d = bem_pkg::DIV_ROUND; state_d = S_DSTART; end
            bem_pkg::DIV_ROUND: begin sel_d = bem_pkg::DIV_PV; state_d = S_DSTART; end
            default:            state_d = S_FINISH;
          endcase
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= bem_pkg::DIV_CONV;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hw/rtl/bem_datapath.sv
// ---------------------------------------------------------------------------
// bem_datapath
// Accumulators, step multipliers, shared restoring divider, result register.
// ---------------------------------------------------------------------------
module bem_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [23:0]         step_i,
  input  bem_pkg::in_item_t   item_i,
  input  bem_pkg::cmd_t       cmd_i,
  output bem_pkg::sts_t       sts_o,
  output bem_pkg::out_item_t  out_o
);

  bem_pkg::in_item_t item_q;
  logic [63:0] e_grid_q, e_batt_q, e_sl_q, e_gb_q;
  logic        gneg_q, bneg_q, gzero_q, bzero_q;
  logic [63:0] life_chg_q, life_dis_q, life_sl_q, life_pv_q;
  logic [63:0] y_pv_q, y_grid_q, y_chg_q, y_dis_q, y_imp_q, y_exp_q, y_loss_q, y_sl_q;
  logic [15:0] conv_q, round_q, pvs_q;
  bem_pkg::out_item_t out_q;

  // divider
  logic [127:0] dividend_q;
  logic [63:0]  den_q, rem_q;
  logic [15:0]  quo_q;
  logic         sat_q, dzero_q;
  logic [6:0]   cnt_q;

  logic [31:0] gmag, bmag;
  assign gmag = item_i.grid_power[31] ? (~item_i.grid_power + 32'd1) : item_i.grid_power;
  assign bmag = item_i.battery_power[31] ?
                (~item_i.battery_power + 32'd1) : item_i.battery_power;

  // full-width energy products, watts times Q8.16 hours
  logic [55:0] e_grid_w, e_batt_w;
  logic [54:0] e_sl_w, e_pv_w, e_gb_w;
  assign e_grid_w = gmag * step_i;
  assign e_batt_w = bmag * step_i;
  assign e_sl_w   = item_q.system_loss_power * step_i;
  assign e_pv_w   = item_q.pv_to_battery * step_i;
  assign e_gb_w   = item_q.grid_to_battery * step_i;

  // numerator times 25600, split into two 32x16 products
  logic [63:0] num_sel, den_sel;
  logic [47:0] p0, p1;
  always_comb begin
    case (cmd_i.div_sel)
      bem_pkg::DIV_CONV:  begin num_sel = life_dis_q; den_sel = life_chg_q; end
      bem_pkg::DIV_ROUND: begin
        num_sel = life_dis_q;
        den_sel = bem_pkg::sat_add(life_chg_q, life_sl_q);
      end
      default:            begin num_sel = life_pv_q; den_sel = life_chg_q; end
    endcase
  end
  assign p0 = num_sel[31:0]  * bem_pkg::PctScale;
  assign p1 = num_sel[63:32] * bem_pkg::PctScale;

  logic [64:0]  rem_sh;
  logic         take;
  logic [63:0]  rem_nx;
  assign rem_sh = {rem_q, dividend_q[127]};
  assign take   = rem_sh[64] || (rem_sh[63:0] >= den_q);
  assign rem_nx = take ? (rem_sh[63:0] - den_q) : rem_sh[63:0];
  assign sts_o.div_last = (cnt_q == 7'd0);

  logic [15:0] quo_res;
  logic        sat_fin;
  assign sat_fin = sat_q || (take && (cnt_q >= 7'd16));
  always_comb begin
    quo_res = quo_q;
    if (take && cnt_q < 7'd16) quo_res[cnt_q[3:0]] = 1'b1;
    if (dzero_q) quo_res = '0;
    else if (sat_fin) quo_res = 16'hFFFF;
  end

  logic [63:0] y_chg_n, y_dis_n, y_sl_n, conv_n;
  assign y_chg_n = bneg_q ? bem_pkg::sat_add(y_chg_q, e_batt_q) : y_chg_q;
  assign y_dis_n = (!bneg_q && !bzero_q) ? bem_pkg::sat_add(y_dis_q, e_batt_q) : y_dis_q;
  assign y_sl_n  = bem_pkg::sat_add(y_sl_q, e_sl_q);
  assign conv_n  = (y_chg_n > y_dis_n) ? (y_chg_n - y_dis_n) : 64'd0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q   <= item_i;
      gneg_q   <= item_i.grid_power[31];
      gzero_q  <= (item_i.grid_power == 32'd0);
      bneg_q   <= item_i.battery_power[31];
      bzero_q  <= (item_i.battery_power == 32'd0);
      e_grid_q <= {8'd0, e_grid_w};
      e_batt_q <= {8'd0, e_batt_w};
    end
    if (cmd_i.energy) begin
      e_sl_q <= {9'd0, e_sl_w};
      e_gb_q <= {9'd0, e_gb_w};
    end
    if (cmd_i.div_start) begin
      dividend_q <= {48'd0, p1 + {16'd0, p0[47:32]}, p0[31:0]};
      den_q  <= den_sel;
      dzero_q <= (life_chg_q == 64'd0);
      rem_q  <= '0;
      quo_q  <= '0;
      sat_q  <= 1'b0;
      cnt_q  <= 7'd127;
    end else if (cmd_i.div_step) begin
      dividend_q <= {dividend_q[126:0], 1'b0};
      rem_q <= rem_nx;
      if (take) begin
        if (cnt_q >= 7'd16) sat_q <= 1'b1;
        else quo_q[cnt_q[3:0]] <= 1'b1;
      end
      cnt_q <= cnt_q - 7'd1;
    end
    if (cmd_i.out_load) begin
      out_q <= '{conv_q, round_q, pvs_q, y_pv_q, y_grid_q, y_chg_q, y_dis_q,
                 y_imp_q, y_exp_q, y_loss_q, y_sl_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_chg_q <= '0; life_dis_q <= '0; life_sl_q <= '0; life_pv_q <= '0;
      y_pv_q <= '0; y_grid_q <= '0; y_chg_q <= '0; y_dis_q <= '0;
      y_imp_q <= '0; y_exp_q <= '0; y_loss_q <= '0; y_sl_q <= '0;
      conv_q <= bem_pkg::PctReset; round_q <= bem_pkg::PctReset; pvs_q <= '0;
    end else begin
      if (cmd_i.year_clr) begin
        y_pv_q <= '0; y_grid_q <= '0; y_chg_q <= '0; y_dis_q <= '0;
        y_imp_q <= '0; y_exp_q <= '0; y_sl_q <= '0;
      end
      if (cmd_i.energy) begin
        if (!gneg_q && !gzero_q) y_exp_q <= bem_pkg::sat_add(y_exp_q, e_grid_q);
        else y_imp_q <= bem_pkg::sat_add(y_imp_q, e_grid_q);
        if (bneg_q) begin
          life_pv_q <= bem_pkg::sat_add(life_pv_q, {9'd0, e_pv_w});
          y_pv_q    <= bem_pkg::sat_add(y_pv_q, {9'd0, e_pv_w});
        end
      end
      if (cmd_i.finish && bneg_q) y_grid_q <= bem_pkg::sat_add(y_grid_q, e_gb_q);
      if (cmd_i.div_store) begin
        case (cmd_i.div_sel)
          bem_pkg::DIV_CONV:  conv_q  <= quo_res;
          bem_pkg::DIV_ROUND: round_q <= quo_res;
          default:            pvs_q   <= quo_res;
        endcase
      end
      if (cmd_i.finish) begin
        if (bneg_q) life_chg_q <= bem_pkg::sat_add(life_chg_q, e_batt_q);
        else if (!bzero_q) life_dis_q <= bem_pkg::sat_add(life_dis_q, e_batt_q);
        life_sl_q <= bem_pkg::sat_add(life_sl_q, e_sl_q);
        y_chg_q  <= y_chg_n;
        y_dis_q  <= y_dis_n;
        y_sl_q   <= y_sl_n;
        y_loss_q <= bem_pkg::sat_add(conv_n, y_sl_n);
      end
    end
  end

  assign out_o = out_q;

endmodule

### hw/rtl/battery_energy_metrics_top.sv
// ---------------------------------------------------------------------------
// battery_energy_metrics_top
// Battery and grid energy bookkeeping with Q8.8 efficiency percentages.
// ---------------------------------------------------------------------------
//  channel   | direction | payload
//  in_ch     | sink      | command, grid/battery power, pv/grid-to-battery, loss
//  out_ch    | source    | three percents, eight annual energies
//  cfg_ch    | sink      | step_hours (Q8.16)
//
// A power sample goes from accept to result through an energy step, then
// three divisions on the single restoring divider, each a start step plus
// 128 steps of one dividend bit, then finish and output. A new-year item
// clears the annual totals except total loss and goes to output. The next
// item can be taken in the cycle after the result is loaded. Reset clears
// all totals; percentages return to 100 and 0 percent. A stalled result
// holds the next item in its output state; no new item enters meanwhile.
// ---------------------------------------------------------------------------
module battery_energy_metrics_top (
  input  logic clk_i,
  input  logic rst_ni,
  bem_if.sink   in_ch,
  bem_if.source out_ch,
  bem_if.sink   cfg_ch
);

  logic [23:0] step_q;
  bem_pkg::cmd_t cmd;
  bem_pkg::sts_t sts;

  // Accept configuration at any time; user must write only when idle, unchecked.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= bem_pkg::StepReset;
    end else if (cfg_ch.valid) begin
      step_q <= cfg_ch.data;
    end
  end

  bem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_cmd_i    (in_ch.data.command),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bem_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step_q),
    .item_i (in_ch.data),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_ch.data)
  );

endmodule

### hw/rtl/bem_checker.sv
// ---------------------------------------------------------------------------
// bem_checker
// Port-level checks on the battery energy metrics block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bem_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  `CHK_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid && in_ready, !in_ready, "ready after accept")
  `CHK_NEXT(a_out_holds, clk_i, rst_ni, out_valid && !out_ready, out_valid, "result dropped")
  `CHK_NEXT(a_no_out_right_after_accept, clk_i, rst_ni, in_valid && in_ready && !out_valid, !out_valid, "result too early")
endmodule

bind battery_energy_metrics_top bem_checker u_bem_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

### test/tb_if.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_if
// Testbench transaction package; mirrors the block's input item for typing.
// ---------------------------------------------------------------------------
// The block's own bem_if is used for the connections; this file only carries
// the transaction type shared by the stimulus tasks.
package tb_txn_pkg;

  typedef struct {
    bem_pkg::cmd_e command;
    logic [31:0]   grid_power;
    logic [31:0]   battery_power;
    logic [30:0]   pv_to_battery;
    logic [30:0]   grid_to_battery;
    logic [30:0]   system_loss_power;
  } sample_txn_t;
endpackage

### test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Checks the battery energy metrics block against a built-in predictor of
// its energy bookkeeping and percentages, under random idling on input and output.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned SampleCycles = 392;
  localparam longint unsigned CycleLimit = 64'd20_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bem_if #(.T(bem_pkg::in_item_t))  in_ch ();
  bem_if #(.T(bem_pkg::out_item_t)) out_ch ();
  bem_if #(.T(logic [23:0]))        cfg_ch ();

  battery_energy_metrics_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: lifetime and annual energies plus percent registers.
  logic [63:0] step_q;
  logic [63:0] life_chg, life_dis, life_sys, life_pv;
  logic [63:0] yr_pv, yr_grid, yr_chg, yr_dis, yr_imp, yr_exp, yr_loss, yr_sys;
  logic [15:0] conv_pct, round_pct, pv_pct;

  bem_pkg::out_item_t expected_results[$];
  int unsigned error_count = 0;
  longint unsigned cycle_count = 0;

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // floor(25600 * num / den), saturated to 16 bits; zero on a zero divisor
  function automatic logic [15:0] percent_of(logic [63:0] num, logic [63:0] den);
    logic [127:0] prod;
    logic [127:0] quo;
    prod = 128'(num) * 128'd25600;
    if (den == 0) return '0;
    quo = prod / 128'(den);
    return (quo > 128'd65535) ? 16'hFFFF : quo[15:0];
  endfunction

  task automatic reset_model();
    step_q = 64'(bem_pkg::StepReset);
    {life_chg, life_dis, life_sys, life_pv} = '0;
    {yr_pv, yr_grid, yr_chg, yr_dis, yr_imp, yr_exp, yr_loss, yr_sys} = '0;
    conv_pct = bem_pkg::PctReset;
    round_pct = bem_pkg::PctReset;
    pv_pct = '0;
  endtask

  // Advance the bookkeeping by one transaction and queue its result.
  task automatic predict_metrics(tb_txn_pkg::sample_txn_t t);
    logic [63:0] gmag, bmag, e_grid, e_batt, e_sl, e_pv, conv;
    logic gneg, bneg;
    bem_pkg::out_item_t r;
    if (t.command == bem_pkg::CMD_NEW_YEAR) begin
      {yr_pv, yr_grid, yr_chg, yr_dis, yr_imp, yr_exp, yr_sys} = '0;
    end else begin
      gneg = t.grid_power[31];
      bneg = t.battery_power[31];
      gmag = 64'(gneg ? 32'(-t.grid_power) : t.grid_power);
      bmag = 64'(bneg ? 32'(-t.battery_power) : t.battery_power);
      e_grid = gmag * step_q;
      e_batt = bmag * step_q;
      e_sl = 64'(t.system_loss_power) * step_q;
      if (!gneg && gmag != 0) yr_exp = add_sat(yr_exp, e_grid);
      else yr_imp = add_sat(yr_imp, e_grid);
      if (bneg) begin
        e_pv = 64'(t.pv_to_battery) * step_q;
        life_pv = add_sat(life_pv, e_pv);
        yr_pv = add_sat(yr_pv, e_pv);
        yr_grid = add_sat(yr_grid, 64'(t.grid_to_battery) * step_q);
      end
      // percentages use lifetime charge/discharge from before this sample
      conv_pct = percent_of(life_dis, life_chg);
      round_pct = life_chg == 0 ? '0 : percent_of(life_dis, add_sat(life_chg, life_sys));
      pv_pct = percent_of(life_pv, life_chg);
      if (bneg) begin
        life_chg = add_sat(life_chg, e_batt);
        yr_chg = add_sat(yr_chg, e_batt);
      end else if (bmag != 0) begin
        life_dis = add_sat(life_dis, e_batt);
        yr_dis = add_sat(yr_dis, e_batt);
      end
      life_sys = add_sat(life_sys, e_sl);
      yr_sys = add_sat(yr_sys, e_sl);
      conv = (yr_chg > yr_dis) ? yr_chg - yr_dis : '0;
      yr_loss = add_sat(conv, yr_sys);
    end
    r.conversion_efficiency = conv_pct;
    r.roundtrip_efficiency = round_pct;
    r.pv_share_percent = pv_pct;
    r.pv_charge_year = yr_pv;
    r.grid_charge_year = yr_grid;
    r.charge_year = yr_chg;
    r.discharge_year = yr_dis;
    r.import_year = yr_imp;
    r.export_year = yr_exp;
    r.total_loss_year = yr_loss;
    r.system_loss_year = yr_sys;
    expected_results.push_back(r);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  task automatic idle_cycles(int unsigned n);
    repeat (n) @(posedge clk_i);
  endtask

  // Drive one transaction and hold it until the block takes it; the edge
  // that drops valid always passes before the next one is driven.
  task automatic send_sample(tb_txn_pkg::sample_txn_t t);
    bem_pkg::in_item_t d;
    idle_cycles(gap_len() + 1);
    d.command = t.command;
    d.grid_power = t.grid_power;
    d.battery_power = t.battery_power;
    d.pv_to_battery = t.pv_to_battery;
    d.grid_to_battery = t.grid_to_battery;
    d.system_loss_power = t.system_loss_power;
    in_ch.valid <= 1'b1;
    in_ch.data <= d;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_metrics(t);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
    idle_cycles(SampleCycles + 10);
  endtask

  // Write step_hours; only called with nothing in flight.
  task automatic write_step(logic [23:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    step_q = 64'(v);
  endtask

  function automatic logic [31:0] rand_power();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(0, 2000)) - 1000);
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [30:0] rand_watts();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return 31'($urandom_range(0, 5000));
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic tb_txn_pkg::sample_txn_t make_sample(bit year_start);
    tb_txn_pkg::sample_txn_t t;
    t.command = year_start ? bem_pkg::CMD_NEW_YEAR : bem_pkg::CMD_SAMPLE;
    t.grid_power = rand_power();
    t.battery_power = rand_power();
    t.pv_to_battery = rand_watts();
    t.grid_to_battery = rand_watts();
    t.system_loss_power = rand_watts();
    return t;
  endfunction

  function automatic tb_txn_pkg::sample_txn_t fixed_sample(logic [31:0] g, logic [31:0] b,
                                                           logic [30:0] pv, logic [30:0] gb,
                                                           logic [30:0] sl);
    tb_txn_pkg::sample_txn_t t;
    t.command = bem_pkg::CMD_SAMPLE;
    t.grid_power = g;
    t.battery_power = b;
    t.pv_to_battery = pv;
    t.grid_to_battery = gb;
    t.system_loss_power = sl;
    return t;
  endfunction

  // Zero charge, both signs, zero grid power, extremes and new year.
  task automatic test_directed();
    tb_txn_pkg::sample_txn_t ny;
    ny = make_sample(1'b1);
    send_sample(fixed_sample(32'd100, 32'd50, 31'd7, 31'd3, 31'd2));
    send_sample(fixed_sample('0, -32'sd400, 31'd300, 31'd100, 31'd5));
    send_sample(fixed_sample(-32'sd20, 32'd200, '0, '0, 31'd1));
    send_sample(fixed_sample('0, '0, '1, '1, '0));
    send_sample(fixed_sample(32'h8000_0000, 32'h8000_0000, '1, '1, '1));
    send_sample(fixed_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, '1));
    send_sample(fixed_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0));
    send_sample(ny);
    send_sample(fixed_sample(32'd1, 32'd1, 31'd1, 31'd1, 31'd1));
    send_sample(ny);
    send_sample(ny);
    wait_drained();
  endtask

  // Largest step with extreme powers, then the smallest step with random ones.
  task automatic test_step_extremes();
    write_step(24'hFF_FFFF);
    repeat (6) send_sample(fixed_sample(32'h8000_0000, 32'h8000_0000, '1, '1, '1));
    repeat (4) send_sample(fixed_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, '1));
    wait_drained();
    write_step(24'd1);
    repeat (4) send_sample(make_sample(1'b0));
    wait_drained();
  endtask

  // Random transactions over several step settings, new years sprinkled in.
  task automatic test_random(int unsigned n);
    logic [23:0] steps[4];
    steps = '{24'd1, 24'h01_0000, 24'h00_4000, 24'hFF_FFFF};
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 450 == 0) begin
        wait_drained();
        write_step(i == 0 ? 24'($urandom_range(1, 24'hFF_FFFF)) : steps[(i / 450) % 4]);
      end
      send_sample(make_sample($urandom_range(0, 29) == 0));
    end
  endtask

  // Hold the sender until every pending result is in, then resume.
  task automatic test_drain_pause();
    repeat (5) send_sample(make_sample(1'b0));
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (5) send_sample(make_sample(1'b0));
    wait_drained();
  endtask

  // Result sink: random stalls, compare each transaction with the oldest entry.
  always @(posedge clk_i) begin
    bem_pkg::out_item_t e;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_ch.data);
          error_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_ch.data !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_ch.data);
            error_count++;
          end
        end
      end
      out_ch.ready <= (cycle_count % 1000 < 700) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    reset_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_step_extremes();
    test_drain_pause();
    test_random(1800);
    wait_drained();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### battery_energy_metrics_top.f
+incdir+hw/rtl
hw/rtl/bem_pkg.sv
hw/rtl/bem_if.sv
hw/rtl/bem_ctrl.sv
hw/rtl/bem_datapath.sv
hw/rtl/battery_energy_metrics_top.sv
hw/rtl/bem_checker.sv
test/tb_if.sv
test/tb_top.sv
